// ----- design/pmsf_pkg.sv -----
// Package for the port MAC security filter: sizes, codes and word types.
`timescale 1ns / 1ps
package pmsf_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int MAC_W = 48;

  localparam logic [2:0] MODE_FRAME  = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_LINK   = 3'd4;

  localparam logic [1:0] VM_SHUTDOWN = 2'd0;
  localparam logic [1:0] VM_RESTRICT = 2'd1;

  localparam logic [1:0] REG_MAX_ADDR  = 2'd0;
  localparam logic [1:0] REG_VIOL_MODE = 2'd1;
  localparam logic [1:0] REG_STICKY    = 2'd2;

  typedef struct packed {
    logic [2:0]       mode;
    logic [MAC_W-1:0] mac_address;
    logic             entry_sticky;
    logic             entry_static;
  } in_word_t;

  typedef struct packed {
    logic        forward;
    logic        address_known;
    logic        violation;
    logic        port_shutdown;
    logic        table_full;
    logic [7:0]  entry_count;
    logic [31:0] violation_total;
  } out_word_t;

  typedef struct packed {
    logic             sticky;
    logic             is_static;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [MAC_W-1:0] key;
    logic             wr_en;
    logic             wr_clr;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
    logic             clear_all;
  } scan_cmd_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } scan_stat_t;

endpackage

// ----- design/pmsf_scan.sv -----
// Address table with valid bits and a serial lookup of match and lowest free entry.
`timescale 1ns / 1ps
module pmsf_scan (
  input  logic                clk,
  input  logic                rst,
  input  pmsf_pkg::scan_cmd_t cmd,
  output pmsf_pkg::scan_stat_t stat
);
  import pmsf_pkg::*;

  entry_t           mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  entry_t           rd_data;
  logic [MAC_W-1:0] key;
  logic             scanning;
  logic [IDX_W-1:0] rd_addr;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_last;
  logic             done;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free;
  logic [IDX_W-1:0] free_idx;
  logic             addr_last;

  assign addr_last = (rd_addr == IDX_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_clr) begin
      mem[cmd.wr_idx] <= cmd.wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clear_all) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[cmd.wr_idx] <= !cmd.wr_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      rd_addr  <= '0;
      cmp_vld  <= 1'b0;
      cmp_last <= 1'b0;
      done     <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
    end else begin
      done    <= cmp_vld && cmp_last;
      cmp_vld <= scanning;
      if (cmd.start) begin
        scanning <= 1'b1;
        rd_addr  <= '0;
        hit      <= 1'b0;
        free     <= 1'b0;
        key      <= cmd.key;
      end else if (scanning) begin
        cmp_idx  <= rd_addr;
        cmp_last <= addr_last;
        if (addr_last) begin
          scanning <= 1'b0;
        end else begin
          rd_addr <= rd_addr + 1'b1;
        end
      end
      if (cmp_vld) begin
        if (valid[cmp_idx] && rd_data.mac == key && !hit) begin
          hit     <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (!valid[cmp_idx] && !free) begin
          free     <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.hit      = hit;
  assign stat.hit_idx  = hit_idx;
  assign stat.free     = free;
  assign stat.free_idx = free_idx;

endmodule

// ----- design/port_mac_security_filter.sv -----
// Top level of the port MAC security filter: sequencer, counters, config and output word.
//
//  channel | signals                               | direction | word
//  in      | in_valid, in_stall, in_word           | input     | in_word_t
//  out     | out_valid, out_stall, out_word        | output    | out_word_t
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | input     | register write
//
// Frame, add, remove and query words scan the whole table: the
// table is read one entry a cycle through its single read port. Link and
// undefined words skip the scan. One word is in work at a time; in_stall is
// high until it is done. A finished result waits in the output register while
// the next word is taken. Reset (rst, synchronous) invalidates the table at once.
`timescale 1ns / 1ps
module port_mac_security_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmsf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pmsf_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import pmsf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} state_t;

  state_t      state;
  in_word_t    item;
  logic [7:0]  max_addresses;
  logic [1:0]  violation_mode;
  logic        sticky_learning;
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] valid_count_next;
  logic [31:0] violation_counter;
  logic [31:0] violation_counter_next;
  logic        err_disabled;
  logic        err_disabled_next;
  out_word_t   res;
  scan_cmd_t   cmd;
  scan_stat_t  stat;
  logic        accept;
  logic        apply;
  logic        lookup;
  logic        known;
  logic        learn_ok;
  logic        cnt_sat;

  pmsf_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign apply     = (state == ST_APPLY) && !(out_valid && out_stall);
  assign lookup    = (item.mode <= MODE_QUERY);
  assign known     = lookup && stat.hit;
  assign learn_ok  = stat.free && (CMP_W'(valid_count) < CMP_W'(max_addresses));
  assign cnt_sat   = (violation_counter == '1);

  always_comb begin
    cmd                    = '0;
    cmd.start              = accept && (in_word.mode <= MODE_QUERY);
    cmd.key                = in_word.mac_address;
    cmd.wr_entry.mac       = item.mac_address;
    res                    = '0;
    valid_count_next       = valid_count;
    violation_counter_next = violation_counter;
    err_disabled_next      = err_disabled;
    case (item.mode)
      MODE_FRAME: begin
        if (err_disabled) begin
          res.forward = 1'b0;
        end else if (stat.hit) begin
          res.forward = 1'b1;
        end else if (learn_ok) begin
          res.forward         = 1'b1;
          cmd.wr_en           = apply;
          cmd.wr_idx          = stat.free_idx;
          cmd.wr_entry.sticky = sticky_learning;
          valid_count_next    = valid_count + 1'b1;
        end else begin
          res.violation = 1'b1;
          if ((violation_mode == VM_SHUTDOWN || violation_mode == VM_RESTRICT) && !cnt_sat) begin
            violation_counter_next = violation_counter + 1'b1;
          end
          if (violation_mode == VM_SHUTDOWN) begin
            err_disabled_next = 1'b1;
          end
        end
      end
      MODE_ADD: begin
        cmd.wr_entry.sticky    = item.entry_sticky;
        cmd.wr_entry.is_static = item.entry_static;
        if (stat.hit) begin
          cmd.wr_en  = apply;
          cmd.wr_idx = stat.hit_idx;
        end else if (stat.free) begin
          cmd.wr_en        = apply;
          cmd.wr_idx       = stat.free_idx;
          valid_count_next = valid_count + 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (stat.hit) begin
          cmd.wr_en        = apply;
          cmd.wr_clr       = 1'b1;
          cmd.wr_idx       = stat.hit_idx;
          valid_count_next = valid_count - 1'b1;
        end
      end
      MODE_LINK: begin
        cmd.clear_all     = apply;
        valid_count_next  = '0;
        err_disabled_next = 1'b0;
      end
      default: begin
      end
    endcase
    res.address_known   = known;
    res.port_shutdown   = err_disabled_next;
    res.entry_count     = 8'(valid_count_next);
    res.violation_total = violation_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      valid_count       <= '0;
      violation_counter <= '0;
      err_disabled      <= 1'b0;
      max_addresses     <= 8'd1;
      violation_mode    <= VM_SHUTDOWN;
      sticky_learning   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_ADDR:  max_addresses   <= cfg_data;
          REG_VIOL_MODE: violation_mode  <= cfg_data[1:0];
          REG_STICKY:    sticky_learning <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall && !apply) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            item  <= in_word;
            state <= (in_word.mode <= MODE_QUERY) ? ST_SCAN : ST_APPLY;
          end
        end
        ST_SCAN: begin
          if (stat.done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply) begin
            out_valid         <= 1'b1;
            out_word          <= res;
            valid_count       <= valid_count_next;
            violation_counter <= violation_counter_next;
            err_disabled      <= err_disabled_next;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_out_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("result word without an apply step");

  a_viol_drops: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.violation && out_word.forward))
    else $error("violating frame forwarded");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_SCAN)
    else $error("scan finished outside of a lookup");

endmodule
